FILE: rtl/core/ncpe_pkg.sv
package ncpe_pkg;

  // Default sizes
  localparam int unsigned MAX_POINTS_DEF = 16;
  localparam int unsigned MAX_ORDER_DEF  = 4;

  // Fixed-point formats
  localparam int unsigned FRAC_BITS = 30;
  localparam int unsigned BASIS_W   = 31;
  localparam int unsigned WEIGHT_W  = 24;
  localparam int unsigned COORD_W   = 32;
  localparam logic [BASIS_W-1:0] BASIS_ONE = 31'h4000_0000;

  // Register reset values
  localparam logic [2:0] ORDER_RST = 3'd4;
  localparam logic [4:0] COUNT_RST = 5'd4;

  typedef enum logic [1:0] {
    MODE_KNOT  = 2'd0,
    MODE_POINT = 2'd1,
    MODE_EVAL  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_INDEX = 2'd1,
    STATUS_BAD_ORDER = 2'd2,
    STATUS_ZERO_WSUM = 2'd3
  } status_e;

  typedef enum logic {
    REG_ORDER = 1'b0,
    REG_COUNT = 1'b1
  } reg_idx_e;

  typedef enum logic [4:0] {
    E_IDLE, E_BND0, E_BND1, E_BND2, E_INIT_RD, E_INIT_WR,
    E_REC_RD, E_FRAC, E_DIV, E_MUL, E_REC_WR,
    E_WS_RD, E_WS_MUL, E_WS_ACC, E_WS_CHK,
    E_CO_RD, E_CO_DW, E_CO_M0, E_CO_M1, E_CO_SUM, E_CO_ACC,
    E_CO_DIV, E_CO_WAIT, E_DONE
  } eval_state_e;

  typedef struct packed {
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [WEIGHT_W-1:0] w;
  } point_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    status_e            status;
  } result_t;

endpackage

FILE: rtl/core/nurbs_curve_point_evaluator_top.sv
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i / in_stall_o | mode, entry_index, param_value, point x/y/weight
// out     | output    | out_valid_o/out_stall_i | curve_x, curve_y, status
// cfg     | input     | cfg_we_i                | cfg_index_i, cfg_wdata_i
//
// Loads write their store at acceptance; res_q holds the result until it moves to out_q.
// An evaluation uses one bit-serial divider. It builds the first basis level, then each
// higher level, then the weight sum, then for each coordinate a weighted sum and a divide
// by the weight sum.
// in_stall_o is high from acceptance until the result moves to the output register.
// Reset clears control state only; knot and point stores start undefined.
module nurbs_curve_point_evaluator_top import ncpe_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF,
  parameter int unsigned MAX_ORDER  = MAX_ORDER_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [4:0]  entry_index_i,
  input  logic [31:0] param_value_i,
  input  logic [31:0] point_x_i,
  input  logic [31:0] point_y_i,
  input  logic [23:0] point_weight_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] curve_x_o,
  output logic [31:0] curve_y_o,
  output logic [1:0]  status_o
);

  localparam int unsigned KD  = MAX_POINTS + MAX_ORDER;
  localparam int unsigned KIW = $clog2(KD);
  localparam int unsigned PIW = $clog2(MAX_POINTS);

  logic [2:0] curve_order_q;
  logic [4:0] point_count_q;
  logic       busy_q, res_valid_q, out_valid_q;
  result_t    res_q, out_q, load_res, eval_res;
  logic       accept, out_free, knot_ok, pt_ok, knot_we, pt_we, eval_start, eval_done;
  point_t     pt_wdata, pt_rdata;

  logic [KIW-1:0]     knot_raddr, bs_waddr, bs_raddr;
  logic [31:0]        knot_rdata;
  logic [PIW-1:0]     pt_raddr;
  logic               bs_we;
  logic [BASIS_W-1:0] bs_wdata, bs_rdata;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      curve_order_q <= ORDER_RST;
      point_count_q <= COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ORDER: curve_order_q <= cfg_wdata_i[2:0];
        REG_COUNT: point_count_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Request decode; loads write the stores at acceptance
  always_comb begin
    accept     = in_valid_i && !in_stall_o;
    out_free   = !out_valid_q || !out_stall_i;
    knot_ok    = 32'(entry_index_i) < KD;
    pt_ok      = 32'(entry_index_i) < MAX_POINTS;
    knot_we    = accept && (mode_i == MODE_KNOT) && knot_ok;
    pt_we      = accept && (mode_i == MODE_POINT) && pt_ok;
    eval_start = accept && (mode_i == MODE_EVAL);
    pt_wdata.x = point_x_i;
    pt_wdata.y = point_y_i;
    pt_wdata.w = point_weight_i;
    load_res.x = '0;
    load_res.y = '0;
    case (mode_i)
      MODE_KNOT:  load_res.status = knot_ok ? STATUS_OK : STATUS_BAD_INDEX;
      MODE_POINT: load_res.status = pt_ok ? STATUS_OK : STATUS_BAD_INDEX;
      default:    load_res.status = STATUS_BAD_INDEX;
    endcase
  end

  // Request tracking and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      res_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
        if (mode_i != MODE_EVAL) res_valid_q <= 1'b1;
      end
      if (eval_done) res_valid_q <= 1'b1;
      if (res_valid_q && out_free) begin
        out_valid_q <= 1'b1;
        res_valid_q <= 1'b0;
        busy_q      <= 1'b0;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept && mode_i != MODE_EVAL) res_q <= load_res;
    if (eval_done) res_q <= eval_res;
    if (res_valid_q && out_free) out_q <= res_q;
  end

  ncpe_mem #(
    .MAX_POINTS (MAX_POINTS),
    .MAX_ORDER  (MAX_ORDER)
  ) u_mem (
    .clk_i        (clk_i),
    .knot_we_i    (knot_we),
    .knot_waddr_i (KIW'(entry_index_i)),
    .knot_wdata_i (param_value_i),
    .knot_raddr_i (knot_raddr),
    .knot_rdata_o (knot_rdata),
    .pt_we_i      (pt_we),
    .pt_waddr_i   (PIW'(entry_index_i)),
    .pt_wdata_i   (pt_wdata),
    .pt_raddr_i   (pt_raddr),
    .pt_rdata_o   (pt_rdata),
    .bs_we_i      (bs_we),
    .bs_waddr_i   (bs_waddr),
    .bs_wdata_i   (bs_wdata),
    .bs_raddr_i   (bs_raddr),
    .bs_rdata_o   (bs_rdata)
  );

  ncpe_eval #(
    .MAX_POINTS (MAX_POINTS),
    .MAX_ORDER  (MAX_ORDER)
  ) u_eval (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (eval_start),
    .t_i           (param_value_i),
    .curve_order_i (curve_order_q),
    .point_count_i (point_count_q),
    .knot_raddr_o  (knot_raddr),
    .knot_rdata_i  (knot_rdata),
    .pt_raddr_o    (pt_raddr),
    .pt_rdata_i    (pt_rdata),
    .bs_we_o       (bs_we),
    .bs_waddr_o    (bs_waddr),
    .bs_wdata_o    (bs_wdata),
    .bs_raddr_o    (bs_raddr),
    .bs_rdata_i    (bs_rdata),
    .done_o        (eval_done),
    .res_o         (eval_res)
  );

  assign in_stall_o  = busy_q;
  assign out_valid_o = out_valid_q;
  assign curve_x_o   = out_q.x;
  assign curve_y_o   = out_q.y;
  assign status_o    = out_q.status;

  // An evaluation completes only for the request in flight
  a_done_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eval_done |-> busy_q && !res_valid_q)
    else $error("evaluation finished with no request in flight");

  // A pending result always belongs to a request in flight
  a_res_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> busy_q)
    else $error("pending result without a request in flight");

  // Accepting a request blocks the next one
  a_accept_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("request taken while another is in flight");

  // Failed requests give a zero point
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != STATUS_OK) |-> (curve_x_o == '0 && curve_y_o == '0))
    else $error("nonzero point with error status");

endmodule

FILE: rtl/core/ncpe_mem.sv
module ncpe_mem import ncpe_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF,
  parameter int unsigned MAX_ORDER  = MAX_ORDER_DEF
) (
  input  logic                                        clk_i,
  input  logic                                        knot_we_i,
  input  logic [$clog2(MAX_POINTS+MAX_ORDER)-1:0]     knot_waddr_i,
  input  logic [31:0]                                 knot_wdata_i,
  input  logic [$clog2(MAX_POINTS+MAX_ORDER)-1:0]     knot_raddr_i,
  output logic [31:0]                                 knot_rdata_o,
  input  logic                                        pt_we_i,
  input  logic [$clog2(MAX_POINTS)-1:0]               pt_waddr_i,
  input  point_t                                      pt_wdata_i,
  input  logic [$clog2(MAX_POINTS)-1:0]               pt_raddr_i,
  output point_t                                      pt_rdata_o,
  input  logic                                        bs_we_i,
  input  logic [$clog2(MAX_POINTS+MAX_ORDER)-1:0]     bs_waddr_i,
  input  logic [BASIS_W-1:0]                          bs_wdata_i,
  input  logic [$clog2(MAX_POINTS+MAX_ORDER)-1:0]     bs_raddr_i,
  output logic [BASIS_W-1:0]                          bs_rdata_o
);

  localparam int unsigned KD = MAX_POINTS + MAX_ORDER;

  logic [31:0]        knot_mem  [KD];
  point_t             pt_mem    [MAX_POINTS];
  logic [BASIS_W-1:0] basis_mem [KD];

  // Knot store, read-first
  always_ff @(posedge clk_i) begin
    if (knot_we_i) begin
      knot_mem[knot_waddr_i] <= knot_wdata_i;
    end
    knot_rdata_o <= knot_mem[knot_raddr_i];
  end

  // Control point store: x, y and weight in one word
  always_ff @(posedge clk_i) begin
    if (pt_we_i) begin
      pt_mem[pt_waddr_i] <= pt_wdata_i;
    end
    pt_rdata_o <= pt_mem[pt_raddr_i];
  end

  // Basis scratch store, rewritten in place level by level
  always_ff @(posedge clk_i) begin
    if (bs_we_i) begin
      basis_mem[bs_waddr_i] <= bs_wdata_i;
    end
    bs_rdata_o <= basis_mem[bs_raddr_i];
  end

endmodule

FILE: rtl/core/ncpe_div.sv
module ncpe_div import ncpe_pkg::*; #(
  parameter int unsigned NUM_W = 90,
  parameter int unsigned DEN_W = 59,
  parameter int unsigned CNT_W = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DEN_W-1:0] rem_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [CNT_W-1:0] iters_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  logic [DEN_W-1:0] r_q, den_q, r_next;
  logic [NUM_W-1:0] q_q;
  logic [CNT_W-1:0] cnt_q;
  logic             run_q, done_q;
  logic [DEN_W:0]   trial, trial_sub;
  logic             ge;

  // One restoring step per cycle
  always_comb begin
    trial     = {r_q, q_q[NUM_W-1]};
    trial_sub = trial - {1'b0, den_q};
    ge        = trial >= {1'b0, den_q};
    r_next    = ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
  end

  // Iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= iters_i;
      end else if (run_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q   <= rem_i;
      q_q   <= num_i;
      den_q <= den_i;
    end else if (run_q) begin
      r_q <= r_next;
      q_q <= {q_q[NUM_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = q_q;

endmodule

FILE: rtl/core/ncpe_eval.sv
module ncpe_eval import ncpe_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF,
  parameter int unsigned MAX_ORDER  = MAX_ORDER_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start_i,
  input  logic [31:0]                             t_i,
  input  logic [2:0]                              curve_order_i,
  input  logic [4:0]                              point_count_i,
  output logic [$clog2(MAX_POINTS+MAX_ORDER)-1:0] knot_raddr_o,
  input  logic [31:0]                             knot_rdata_i,
  output logic [$clog2(MAX_POINTS)-1:0]           pt_raddr_o,
  input  point_t                                  pt_rdata_i,
  output logic                                    bs_we_o,
  output logic [$clog2(MAX_POINTS+MAX_ORDER)-1:0] bs_waddr_o,
  output logic [BASIS_W-1:0]                      bs_wdata_o,
  output logic [$clog2(MAX_POINTS+MAX_ORDER)-1:0] bs_raddr_o,
  input  logic [BASIS_W-1:0]                      bs_rdata_i,
  output logic                                    done_o,
  output result_t                                 res_o
);

  localparam int unsigned KD     = MAX_POINTS + MAX_ORDER;
  localparam int unsigned KIW    = $clog2(KD);
  localparam int unsigned PIW    = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W  = $clog2(KD + 2);
  localparam int unsigned JW     = $clog2(MAX_ORDER + 1);
  localparam int unsigned DW_W   = BASIS_W + WEIGHT_W;
  localparam int unsigned WS_W   = DW_W + PIW;
  localparam int unsigned PROD_W = COORD_W + DW_W - 1;
  localparam int unsigned NUM_W  = PROD_W + PIW;
  localparam int unsigned LO_W   = 28;
  localparam int unsigned HI_W   = DW_W - LO_W;
  localparam int unsigned QC_W   = $clog2(NUM_W + 1);
  localparam int unsigned FP_W   = 2 * BASIS_W;

  eval_state_e state_q, state_d;

  logic [CNT_W-1:0] i_q, nk, n_c, k_c, j_c, ip1, ip2, ipj, ipjm1, ipj1;
  logic [JW-1:0]    j_q;
  logic [2:0]       ph_q;
  logic             term_q, coord_q;

  logic [31:0]        t_q, lo_q, x_q, prev_q, ti_q, ti1_q, tij1_q, tij_q, acc_q;
  logic [BASIS_W-1:0] bi_q, bi1_q, frac_q;
  logic [DW_W-1:0]    dw_q;
  logic [WS_W-1:0]    wsum_q;
  logic [31:0]        mag_q;
  logic               cneg_q, sgn_q;
  logic [COORD_W+LO_W-1:0] plo_q;
  logic [COORD_W+HI_W-1:0] phi_q;
  logic [PROD_W-1:0]  prod_q;
  logic [NUM_W-1:0]   pos_q, neg_q;
  logic [31:0]        rx_q, ry_q;
  status_e            status_q;

  logic               cfg_bad;
  logic [31:0]        hi_b, x_lo, x_clamp;
  logic               t_valid, f_zero, f_one;
  logic [31:0]        hi_v, lo_v, den_v, diff_v;
  logic [BASIS_W-1:0] b_sel;
  logic [FP_W-1:0]    fprod;
  logic [PROD_W:0]    prod_full;
  logic [NUM_W-1:0]   co_mag;
  logic [31:0]        coord_v, sat_v;

  logic               div_start, div_done;
  logic [WS_W-1:0]    div_rem, div_den;
  logic [NUM_W-1:0]   div_num, div_quot;
  logic [QC_W-1:0]    div_iters;

  // Index arithmetic
  always_comb begin
    n_c   = CNT_W'(point_count_i);
    k_c   = CNT_W'(curve_order_i);
    nk    = n_c + k_c;
    j_c   = CNT_W'(j_q);
    ip1   = i_q + CNT_W'(1);
    ip2   = i_q + CNT_W'(2);
    ipj   = i_q + j_c;
    ipjm1 = ipj - CNT_W'(1);
    ipj1  = ipj + CNT_W'(1);
    cfg_bad = (curve_order_i == 3'd0) || (32'(curve_order_i) > MAX_ORDER) ||
              (point_count_i == 5'd0) || (32'(point_count_i) > MAX_POINTS) ||
              (point_count_i < 5'(curve_order_i));
  end

  // Parameter clamp: upper bound wins over lower bound
  always_comb begin
    hi_b    = (knot_rdata_i == 32'd0) ? 32'd0 : knot_rdata_i - 32'd1;
    x_lo    = (t_q < lo_q) ? lo_q : t_q;
    x_clamp = (x_lo > hi_b) ? hi_b : x_lo;
  end

  // Operands of the current Cox-de Boor term
  always_comb begin
    if (!term_q) begin
      t_valid = (tij1_q > ti_q) && (bi_q != '0);
      hi_v    = x_q;
      lo_v    = ti_q;
      den_v   = tij1_q - ti_q;
      b_sel   = bi_q;
    end else begin
      t_valid = (tij_q > ti1_q) && (bi1_q != '0);
      hi_v    = tij_q;
      lo_v    = x_q;
      den_v   = tij_q - ti1_q;
      b_sel   = bi1_q;
    end
    diff_v = hi_v - lo_v;
    f_zero = !t_valid || (hi_v <= lo_v);
    f_one  = diff_v >= den_v;
    fprod  = FP_W'(frac_q) * FP_W'(b_sel);
  end

  // Coordinate accumulation and saturation
  always_comb begin
    coord_v   = coord_q ? pt_rdata_i.y : pt_rdata_i.x;
    prod_full = (PROD_W+1)'(plo_q) + ((PROD_W+1)'(phi_q) << LO_W);
    co_mag    = (pos_q >= neg_q) ? pos_q - neg_q : neg_q - pos_q;
    if (!sgn_q) begin
      sat_v = (div_quot > NUM_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : div_quot[31:0];
    end else begin
      sat_v = (div_quot > NUM_W'(32'h8000_0000)) ? 32'h8000_0000
                                                 : 32'd0 - div_quot[31:0];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      E_IDLE:    if (start_i) state_d = cfg_bad ? E_DONE : E_BND0;
      E_BND0:    state_d = E_BND1;
      E_BND1:    state_d = E_BND2;
      E_BND2:    state_d = E_INIT_RD;
      E_INIT_RD: state_d = E_INIT_WR;
      E_INIT_WR: begin
        if (ip2 < nk) state_d = E_INIT_RD;
        else if (k_c >= CNT_W'(2)) state_d = E_REC_RD;
        else state_d = E_WS_RD;
      end
      E_REC_RD:  if (ph_q == 3'd4) state_d = E_FRAC;
      E_FRAC: begin
        if (f_zero) state_d = term_q ? E_REC_WR : E_FRAC;
        else if (f_one) state_d = E_MUL;
        else state_d = E_DIV;
      end
      E_DIV:     if (div_done) state_d = E_MUL;
      E_MUL:     state_d = term_q ? E_REC_WR : E_FRAC;
      E_REC_WR: begin
        if (ipj1 < nk || j_c < k_c) state_d = E_REC_RD;
        else state_d = E_WS_RD;
      end
      E_WS_RD:   state_d = E_WS_MUL;
      E_WS_MUL:  state_d = E_WS_ACC;
      E_WS_ACC:  state_d = (ip1 < n_c) ? E_WS_RD : E_WS_CHK;
      E_WS_CHK:  state_d = (wsum_q == '0) ? E_DONE : E_CO_RD;
      E_CO_RD:   state_d = E_CO_DW;
      E_CO_DW:   state_d = E_CO_M0;
      E_CO_M0:   state_d = E_CO_M1;
      E_CO_M1:   state_d = E_CO_SUM;
      E_CO_SUM:  state_d = E_CO_ACC;
      E_CO_ACC:  state_d = (ip1 < n_c) ? E_CO_RD : E_CO_DIV;
      E_CO_DIV:  state_d = E_CO_WAIT;
      E_CO_WAIT: if (div_done) state_d = coord_q ? E_DONE : E_CO_RD;
      E_DONE:    state_d = E_IDLE;
      default:   state_d = E_IDLE;
    endcase
  end

  // Memory ports, divider launch, completion
  always_comb begin
    knot_raddr_o = '0;
    pt_raddr_o   = i_q[PIW-1:0];
    bs_raddr_o   = i_q[KIW-1:0];
    bs_we_o      = 1'b0;
    bs_waddr_o   = i_q[KIW-1:0];
    bs_wdata_o   = '0;
    div_start    = 1'b0;
    div_rem      = '0;
    div_num      = '0;
    div_den      = '0;
    div_iters    = '0;
    done_o       = 1'b0;
    case (state_q)
      E_BND1:    knot_raddr_o = ipjm1[KIW-1:0] - ipjm1[KIW-1:0] + (nk - CNT_W'(1));
      E_INIT_RD: knot_raddr_o = ip1[KIW-1:0];
      E_INIT_WR: begin
        bs_we_o    = 1'b1;
        bs_wdata_o = ((prev_q <= x_q) && (x_q < knot_rdata_i)) ? BASIS_ONE : '0;
      end
      E_REC_RD: begin
        case (ph_q)
          3'd0:    knot_raddr_o = i_q[KIW-1:0];
          3'd1:    knot_raddr_o = ip1[KIW-1:0];
          3'd2:    knot_raddr_o = ipjm1[KIW-1:0];
          default: knot_raddr_o = ipj[KIW-1:0];
        endcase
        bs_raddr_o = (ph_q == 3'd0) ? i_q[KIW-1:0] : ip1[KIW-1:0];
      end
      E_FRAC: begin
        if (!f_zero && !f_one) begin
          div_start = 1'b1;
          div_rem   = WS_W'(diff_v);
          div_den   = WS_W'(den_v);
          div_iters = QC_W'(FRAC_BITS);
        end
      end
      E_REC_WR: begin
        bs_we_o    = 1'b1;
        bs_wdata_o = (acc_q > 32'(BASIS_ONE)) ? BASIS_ONE : acc_q[BASIS_W-1:0];
      end
      E_CO_DIV: begin
        div_start = 1'b1;
        div_num   = co_mag;
        div_den   = wsum_q;
        div_iters = QC_W'(NUM_W);
      end
      E_DONE:    done_o = 1'b1;
      default: ;
    endcase
  end

  // Sequencer counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      ph_q    <= '0;
      term_q  <= 1'b0;
      coord_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        E_BND2: i_q <= '0;
        E_INIT_WR: begin
          if (ip2 < nk) begin
            i_q <= ip1;
          end else begin
            i_q <= '0;
            j_q <= JW'(2);
          end
        end
        E_REC_RD: begin
          if (ph_q == 3'd4) begin
            ph_q   <= '0;
            term_q <= 1'b0;
          end else begin
            ph_q <= ph_q + 3'd1;
          end
        end
        E_FRAC: if (f_zero) term_q <= 1'b1;
        E_MUL:  term_q <= 1'b1;
        E_REC_WR: begin
          if (ipj1 < nk) begin
            i_q <= ip1;
          end else if (j_c < k_c) begin
            j_q <= j_q + JW'(1);
            i_q <= '0;
          end else begin
            i_q <= '0;
          end
        end
        E_WS_ACC: i_q <= (ip1 < n_c) ? ip1 : '0;
        E_WS_CHK: coord_q <= 1'b0;
        E_CO_ACC: if (ip1 < n_c) i_q <= ip1;
        E_CO_WAIT: begin
          if (div_done) begin
            coord_q <= 1'b1;
            i_q     <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      E_IDLE: begin
        if (start_i) begin
          t_q      <= t_i;
          rx_q     <= '0;
          ry_q     <= '0;
          status_q <= cfg_bad ? STATUS_BAD_ORDER : STATUS_OK;
        end
      end
      E_BND1:    lo_q <= knot_rdata_i;
      E_BND2: begin
        x_q    <= x_clamp;
        prev_q <= lo_q;
        wsum_q <= '0;
      end
      E_INIT_WR: prev_q <= knot_rdata_i;
      E_REC_RD: begin
        case (ph_q)
          3'd1: begin
            ti_q <= knot_rdata_i;
            bi_q <= bs_rdata_i;
          end
          3'd2: begin
            ti1_q <= knot_rdata_i;
            bi1_q <= bs_rdata_i;
          end
          3'd3: tij1_q <= knot_rdata_i;
          3'd4: begin
            tij_q <= knot_rdata_i;
            acc_q <= '0;
          end
          default: ;
        endcase
      end
      E_FRAC:    if (f_one) frac_q <= BASIS_ONE;
      E_DIV:     if (div_done) frac_q <= BASIS_W'(div_quot[FRAC_BITS-1:0]);
      E_MUL:     acc_q <= acc_q + 32'(fprod[FRAC_BITS +: BASIS_W]);
      E_WS_MUL:  dw_q <= DW_W'(bs_rdata_i) * DW_W'(pt_rdata_i.w);
      E_WS_ACC:  wsum_q <= wsum_q + WS_W'(dw_q);
      E_WS_CHK: begin
        if (wsum_q == '0) status_q <= STATUS_ZERO_WSUM;
        pos_q <= '0;
        neg_q <= '0;
      end
      E_CO_DW: begin
        dw_q   <= DW_W'(bs_rdata_i) * DW_W'(pt_rdata_i.w);
        mag_q  <= coord_v[31] ? 32'd0 - coord_v : coord_v;
        cneg_q <= coord_v[31];
      end
      E_CO_M0:   plo_q <= (COORD_W+LO_W)'(mag_q) * (COORD_W+LO_W)'(dw_q[LO_W-1:0]);
      E_CO_M1:   phi_q <= (COORD_W+HI_W)'(mag_q) * (COORD_W+HI_W)'(dw_q[DW_W-1:LO_W]);
      E_CO_SUM:  prod_q <= prod_full[PROD_W-1:0];
      E_CO_ACC: begin
        if (cneg_q) neg_q <= neg_q + NUM_W'(prod_q);
        else pos_q <= pos_q + NUM_W'(prod_q);
      end
      E_CO_DIV:  sgn_q <= !(pos_q >= neg_q);
      E_CO_WAIT: begin
        if (div_done) begin
          if (coord_q) ry_q <= sat_v;
          else rx_q <= sat_v;
          pos_q <= '0;
          neg_q <= '0;
        end
      end
      default: ;
    endcase
  end

  // Shared divider: basis fractions and final rational quotient
  ncpe_div #(
    .NUM_W (NUM_W),
    .DEN_W (WS_W),
    .CNT_W (QC_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .rem_i   (div_rem),
    .num_i   (div_num),
    .den_i   (div_den),
    .iters_i (div_iters),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign res_o.x      = rx_q;
  assign res_o.y      = ry_q;
  assign res_o.status = status_q;

endmodule
